>>> rtl/npcs_pkg.sv
// shared types, constants and helpers for the nearest palette color search
// no dependencies
`default_nettype none

package npcs_pkg;

  // request codes carried on req_type
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // palette word layout {r6, g6, b6}
  localparam int unsigned COMP_W   = 6;
  localparam int unsigned WORD_W   = 3 * COMP_W;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned SQ_W     = 2 * CHAN_W;
  localparam int unsigned DIST_W   = 18;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_e;

  // squared distance of one channel against a stored 6-bit component scaled by 4
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] pix,
                                              input logic [COMP_W-1:0] comp);
    logic [CHAN_W-1:0] scaled;
    logic [CHAN_W-1:0] diff;
    scaled = {comp, 2'b00};
    diff   = (pix > scaled) ? (pix - scaled) : (scaled - pix);
    return SQ_W'(diff) * SQ_W'(diff);
  endfunction

endpackage

`default_nettype wire

>>> rtl/nearest_palette_color_search.sv
// top level of the nearest palette color search: palette memory, sweep control,
// distance pipeline and best-match tracking; depends on npcs_pkg
`default_nettype none

// A word is taken when start_i is high and busy_o is low. A palette write
// (req_type_i = 1) is stored in the same edge if entry_index_i is below
// PALETTE_DEPTH; it gives no result and never raises busy_o. A pixel with
// alpha 0 gives index 0 in the cycle after it is taken, also without raising
// busy_o. Any other pixel sweeps the palette memory one entry per cycle over
// min(SEARCH_ENTRIES, PALETTE_DEPTH) entries, then drains the read and
// distance stages; busy_o stays high all the while, and the result shows in
// the same cycle that busy_o falls. The single read port of the palette
// memory sets the pace of the sweep. Each result is shown for exactly one
// cycle on color_index_o with done_o high; the receiver cannot stall it. A
// new word may be taken in the very cycle a result is shown.
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH  = 256,
  parameter int unsigned SEARCH_ENTRIES = 224
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              req_type_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] alpha_i,
  input  wire logic [7:0]        entry_index_i,
  output logic                   done_o,
  output logic [7:0]             color_index_o
);

  localparam int unsigned AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned LIMIT = (SEARCH_ENTRIES < PALETTE_DEPTH) ?
                                  SEARCH_ENTRIES : PALETTE_DEPTH;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LIMIT - 1);

  // palette memory, one write and one registered read port
  logic [WORD_W-1:0] mem_q [PALETTE_DEPTH];

  state_e          state_q, state_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic            rd_en;

  // pipeline: stage 1 holds the memory word, stage 2 the channel squares
  logic              v1_q, v2_q;
  logic              last1_q, last2_q;
  logic [AW-1:0]     idx1_q, idx2_q;
  logic [WORD_W-1:0] rd_data_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;

  // pixel under search and running best match
  logic [CHAN_W-1:0] pix_r_q, pix_g_q, pix_b_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [AW-1:0]     best_idx_q;

  logic              done_q;
  logic [7:0]        color_q;

  logic              accept;
  logic              wr_en;
  logic              pix_start;
  logic              transparent;
  logic [DIST_W-1:0] cand_dist;
  logic              better;
  logic              finish;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign wr_en       = accept && (req_type_i == REQ_WRITE) &&
                       ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));
  assign transparent = accept && (req_type_i == REQ_PIXEL) && (alpha_i == '0);
  assign pix_start   = accept && (req_type_i == REQ_PIXEL) && (alpha_i != '0);

  // stage 3: sum of squares against the best so far, strict less keeps the first
  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  assign better    = cand_dist < best_dist_q;
  assign finish    = v2_q && last2_q;

  // sweep control
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pix_start) begin
          state_d = ST_SEARCH;
          addr_d  = '0;
        end
      end
      ST_SEARCH: begin
        rd_en  = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last entry to reach the compare
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      done_q  <= transparent || finish;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i[AW-1:0]] <= {red_i[COMP_W-1:0], green_i[COMP_W-1:0],
                                       blue_i[COMP_W-1:0]};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    idx1_q  <= addr_q;
    last1_q <= (addr_q == LAST_ADDR);
    idx2_q  <= idx1_q;
    last2_q <= last1_q;
    sq_r_q  <= sq_diff(pix_r_q, rd_data_q[3*COMP_W-1:2*COMP_W]);
    sq_g_q  <= sq_diff(pix_g_q, rd_data_q[2*COMP_W-1:COMP_W]);
    sq_b_q  <= sq_diff(pix_b_q, rd_data_q[COMP_W-1:0]);

    if (pix_start) begin
      pix_r_q     <= red_i;
      pix_g_q     <= green_i;
      pix_b_q     <= blue_i;
      best_dist_q <= DIST_START;
      best_idx_q  <= '0;
    end else if (v2_q && better) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= idx2_q;
    end

    if (transparent) begin
      color_q <= '0;
    end else if (finish) begin
      color_q <= better ? 8'(idx2_q) : 8'(best_idx_q);
    end
  end

  assign done_o        = done_q;
  assign color_index_o = color_q;

  // a result never shows while a sweep is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // the pipeline is empty whenever the controller is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("pipeline busy while idle");

  // a transparent pixel answers index zero in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    transparent |=> (done_o && (color_index_o == 8'd0)))
    else $error("transparent pixel not answered with zero");

  // the last compare ends the sweep and raises the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (done_o && !busy_o))
    else $error("sweep end without result");

endmodule

`default_nettype wire

>>> verif/palette_match_checker.sv
`timescale 1ns / 100ps
// checker for the nearest palette color search: mirrors palette writes, predicts
// the color index of each pixel word and compares it with every result; uses npcs_pkg
module palette_match_checker import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH  = 256,
  parameter int unsigned SEARCH_ENTRIES = 224
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic              req_type_i,
  input  wire logic [CHAN_W-1:0] red_i,
  input  wire logic [CHAN_W-1:0] green_i,
  input  wire logic [CHAN_W-1:0] blue_i,
  input  wire logic [CHAN_W-1:0] alpha_i,
  input  wire logic [7:0]        entry_index_i,
  input  wire logic              done_i,
  input  wire logic [7:0]        color_index_i,
  output int                     pending_o,
  output int                     fail_count_o
);

  logic [WORD_W-1:0] palette_copy [PALETTE_DEPTH];
  logic [7:0]        expected_indices [$];
  logic [7:0]        oldest_index;

  function automatic int unsigned chan_dist(input logic [CHAN_W-1:0] pix,
                                            input logic [COMP_W-1:0] comp);
    int d;
    d = int'(pix) - int'({comp, 2'b00});
    return d * d;
  endfunction

  // first entry with the strictly smallest squared rgb distance
  function automatic logic [7:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
    int unsigned       span;
    int unsigned       best_dist;
    int unsigned       cand_dist;
    logic [7:0]        best;
    logic [WORD_W-1:0] w;
    span      = (SEARCH_ENTRIES < PALETTE_DEPTH) ? SEARCH_ENTRIES : PALETTE_DEPTH;
    best      = '0;
    best_dist = 3 * 256 * 256;
    for (int unsigned i = 0; i < span; i++) begin
      w         = palette_copy[i];
      cand_dist = chan_dist(r, w[3*COMP_W-1 -: COMP_W])
                + chan_dist(g, w[2*COMP_W-1 -: COMP_W])
                + chan_dist(b, w[COMP_W-1:0]);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = 8'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_indices.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results first: a word taken in the same edge is younger
      if (done_i) begin
        if (expected_indices.size() == 0) begin
          $error("color_index: unexpected result %0d", color_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          oldest_index = expected_indices.pop_front();
          if (color_index_i !== oldest_index) begin
            $error("color_index mismatch: expected %0d, actual %0d",
                   oldest_index, color_index_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (req_type_i == REQ_WRITE) begin
          if (entry_index_i < PALETTE_DEPTH)
            palette_copy[entry_index_i] = {red_i[COMP_W-1:0], green_i[COMP_W-1:0],
                                           blue_i[COMP_W-1:0]};
        end else if (alpha_i == '0) begin
          expected_indices.push_back(8'd0);
        end else begin
          expected_indices.push_back(nearest_entry(red_i, green_i, blue_i));
        end
      end
      pending_o <= expected_indices.size();
    end
  end

endmodule

>>> verif/nearest_palette_color_search_test.sv
`timescale 1ns / 100ps
// top of the nearest palette color search test: clock, reset, word stimulus,
// watchdog and verdict; depends on npcs_pkg, palette_match_checker and the block
module nearest_palette_color_search_test;
  import npcs_pkg::*;

  localparam int unsigned PALETTE_DEPTH  = 256;
  localparam int unsigned SEARCH_ENTRIES = 224;
  localparam int          RANDOM_WORDS   = 2000;
  localparam int          CALM_TAIL      = 300;   // last words go back to back
  // longest quiet stretch of a correct run is one palette search
  localparam int          STALL_LIMIT    = 3000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              req_type = REQ_PIXEL;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic [CHAN_W-1:0] alpha = '0;
  logic [7:0]        entry_index = '0;
  logic              busy;
  logic              done;
  logic [7:0]        color_index;

  int pending;
  int fail_count;
  int stall_cycles = 0;
  int n_writes = 0;
  int n_clear = 0;
  int n_search = 0;
  bit idling_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_palette_color_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .SEARCH_ENTRIES(SEARCH_ENTRIES)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .req_type_i   (req_type),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .alpha_i      (alpha),
    .entry_index_i(entry_index),
    .done_o       (done),
    .color_index_o(color_index)
  );

  palette_match_checker #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .SEARCH_ENTRIES(SEARCH_ENTRIES)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_type_i   (req_type),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .alpha_i      (alpha),
    .entry_index_i(entry_index),
    .done_i       (done),
    .color_index_i(color_index),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // watchdog: any taken word or shown result counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("nearest_palette_color_search: mismatch");
      $finish;
    end
  end

  // present one word and hold it until the block takes it; start stays high
  // across back-to-back words so it is never dropped and raised in one step
  task automatic send_word(input logic req, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a,
                           input logic [7:0] idx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= req;
    red         <= r;
    green       <= g;
    blue        <= b;
    alpha       <= a;
    entry_index <= idx;
    do @(posedge clk); while (busy);
    if (req == REQ_WRITE) n_writes++;
    else if (a == '0) n_clear++;
    else n_search++;
  endtask

  // sender holds off until every pixel word has its result
  task automatic wait_drained;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one of four coarse levels per channel, so palettes hold many equal colors
  function automatic logic [5:0] coarse_level;
    case ($urandom_range(0, 3))
      0:       return 6'd0;
      1:       return 6'd21;
      2:       return 6'd42;
      default: return 6'd63;
    endcase
  endfunction

  // raw palette byte: junk in the two upper bits, low six bits random or coarse
  function automatic logic [7:0] palette_byte;
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    return {2'($urandom), coarse_level()};
  endfunction

  // pixel channel: full range, the extremes, or right on a coarse level
  function automatic logic [7:0] pixel_byte;
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return {coarse_level(), 2'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] a;
    int         pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // transparent pixels need no palette, so they may come first
    send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);

    // load every entry before any search reads the palette
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_word(REQ_WRITE, palette_byte(), palette_byte(), palette_byte(), 8'($urandom),
                8'(i));

    // upper bits of the raw bytes are dropped: all ones stores 63, 0xC0 stores 0
    send_word(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    send_word(REQ_WRITE, 8'hC0, 8'h40, 8'h80, 8'h00, 8'd1);
    send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00);
    // equal colors at two entries: the lower index has to win the tie
    send_word(REQ_WRITE, 8'h20, 8'h10, 8'h08, 8'h00, 8'd200);
    send_word(REQ_WRITE, 8'h60, 8'h50, 8'h48, 8'h7F, 8'd100);
    send_word(REQ_PIXEL, 8'd128, 8'd64, 8'd32, 8'h80, 8'h00);
    send_word(REQ_PIXEL, 8'd130, 8'd66, 8'd34, 8'h80, 8'h00);
    // last searched entry, and entries past the search that must never win
    send_word(REQ_WRITE, 8'h3F, 8'h00, 8'h3F, 8'h00, 8'd223);
    send_word(REQ_PIXEL, 8'd252, 8'd0, 8'd252, 8'hFE, 8'hFF);
    send_word(REQ_WRITE, 8'h3A, 8'h05, 8'h11, 8'h00, 8'd224);
    send_word(REQ_WRITE, 8'h3A, 8'h05, 8'h11, 8'h00, 8'd255);
    send_word(REQ_PIXEL, 8'd232, 8'd20, 8'd68, 8'h55, 8'h00);
    // transparent pixels back to back, alpha ignored on writes
    send_word(REQ_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h00, 8'h00);
    send_word(REQ_PIXEL, 8'h55, 8'hAA, 8'h55, 8'h00, 8'h80);
    send_word(REQ_WRITE, 8'h2A, 8'h15, 8'h2A, 8'hFF, 8'd2);
    send_word(REQ_PIXEL, 8'hA8, 8'h54, 8'hA8, 8'hAA, 8'h00);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) wait_drained();
      if (i == RANDOM_WORDS - CALM_TAIL) idling_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_word(REQ_WRITE, palette_byte(), palette_byte(), palette_byte(), 8'($urandom),
                  8'($urandom));
      end else begin
        // mostly opaque pixels, one in five transparent
        a = (pick < 48) ? 8'h00 : (pick < 52 ? 8'hFF : 8'($urandom_range(1, 255)));
        send_word(REQ_PIXEL, pixel_byte(), pixel_byte(), pixel_byte(), a, 8'($urandom));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d words: %0d palette writes, %0d transparent, %0d searched pixels",
             n_writes + n_clear + n_search, n_writes, n_clear, n_search);
    $display("sender idle bursts, one drained pause and a back-to-back tail were applied");
    if (fail_count == 0) begin
      $display("nearest_palette_color_search: match");
    end else begin
      $display("nearest_palette_color_search: mismatch");
    end
    $finish;
  end

endmodule
